// ===== rtl/smr_pkg.sv =====
// Shared types and constants for the sorted marker relative lookup block.
// Holds the operation codes and the control bundle broadcast to every cell.
// No dependencies.
package smr_pkg;

  localparam int unsigned FRAME_W         = 16;
  localparam int unsigned OFFSET_W        = 8;
  localparam int unsigned MAX_MARKERS_DEF = 64;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Broadcast to the whole row of cells in the same cycle.
  typedef struct packed {
    logic               ins_en;  // shift-insert key at its sorted place
    logic               cmp_en;  // capture the compare flag
    logic               cmp_lt;  // 1: flag = value < key, 0: flag = value <= key
    logic [FRAME_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/sorted_marker_relative_lookup.sv =====
// Top level of the sorted marker relative lookup block.
// Builds a row of smr_cell instances and the query sequencer around it.
// Depends on smr_pkg and smr_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per operation:
//   op_i selects clear, insert, query or no operation. Output channel
//   (out_valid_o / out_stall_i) returns exactly one beat per input beat with
//   frame_o (query result, else 0) and status_o (1 when an insert was dropped
//   because the table was full).
//   The table lives in a row of cells, kept ascending. An insert is done in
//   the accept cycle: every cell holding a larger value takes its left
//   neighbor's value, and the first such cell (or the cell at the fill count)
//   takes the new value. Clear just zeroes the fill count.
//   A query walks compare (current frame), encode, anchor read, compare
//   (anchor), target select and read in the sequencer, the two compares
//   running in parallel across the row and thermometer encodes giving the
//   marker counts. Clear, insert and no-op finish in the accept cycle.
//   Every beat then passes through the result slot, and no new beat is
//   accepted until that slot has drained into the output register.
//   The output register lets the next beat be accepted while a result is
//   still waiting to be taken.
//   Reset empties the table (fill count zero) and drops any pending result.
//   While the receiver stalls, the output beat holds; a further finished
//   result waits in the sequencer, which then stalls the input.
module sorted_marker_relative_lookup import smr_pkg::*; #(
  parameter int unsigned MAX_MARKERS = MAX_MARKERS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [FRAME_W-1:0]         marker_value_i,
  input  logic [FRAME_W-1:0]         current_frame_i,
  input  logic signed [OFFSET_W-1:0] marker_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [FRAME_W-1:0]         frame_o,
  output logic                       status_o
);

  localparam int unsigned N  = MAX_MARKERS;
  localparam int unsigned CW = $clog2(N + 1);              // fill count width
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;    // cell index width
  localparam int unsigned SW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,  // flag = value <= current frame
    S_ENC  = 7'b0000100,  // count markers at or below current frame
    S_ANC  = 7'b0001000,  // read the anchor marker
    S_CMP2 = 7'b0010000,  // flag = value < anchor
    S_SEL  = 7'b0100000,  // count markers below anchor, pick target
    S_RD   = 7'b1000000   // read target marker
  } state_e;

  // The result slot is modeled as a pending flag so S_IDLE stays the only
  // accepting state.
  state_e state_q, state_d;
  logic   pend_q, pend_d;

  logic [CW-1:0]               cnt_q, cnt_d;
  logic [FRAME_W-1:0]          cur_q, cur_d;
  logic signed [OFFSET_W-1:0]  off_q, off_d;
  logic [CW-1:0]               above_q, above_d;
  logic [FRAME_W-1:0]          anchor_q, anchor_d;
  logic [IW-1:0]               tgt_q, tgt_d;
  logic                        tgt_ok_q, tgt_ok_d;
  logic                        use_anc_q, use_anc_d;
  logic [FRAME_W-1:0]          res_frame_q, res_frame_d;
  logic                        res_status_q, res_status_d;

  logic                        out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]          frame_q, frame_d;
  logic                        status_q, status_d;

  cell_ctrl_t                  ctrl;
  logic [FRAME_W-1:0]          cell_val [N];
  logic [FRAME_W-1:0]          cell_rd  [N];
  logic [N-1:0]                cell_gt;
  logic [N-1:0]                cell_flag;
  logic [N-1:0]                cell_sel;
  logic [FRAME_W-1:0]          rd_or;
  logic [CW-1:0]               flag_cnt;

  logic                        accept;
  logic                        slot_free;
  op_e                         op;

  assign op        = op_e'(op_i);
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || pend_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Cell row: each cell sees its left neighbor's value and greater flag.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [FRAME_W-1:0] left_val;
    logic               left_gt;
    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    always_comb begin
      cell_sel[i] = 1'b0;
      if (state_q == S_ANC) begin
        cell_sel[i] = (CW'(i + 1) == above_q);
      end else if (state_q == S_RD) begin
        cell_sel[i] = (IW'(i) == tgt_q);
      end
    end

    smr_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CW'(i) < cnt_q),
      .at_end_i   (CW'(i) == cnt_q),
      .left_val_i (left_val),
      .left_gt_i  (left_gt),
      .sel_i      (cell_sel[i]),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .flag_o     (cell_flag[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // OR the one-hot read lanes together.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < N; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Flags form a thermometer (sorted row); find the single boundary.
  always_comb begin
    logic lo, hi;
    flag_cnt = '0;
    for (int j = 0; j <= N; j++) begin
      lo = (j == 0) ? 1'b1 : cell_flag[j-1];
      hi = (j == N) ? 1'b1 : !cell_flag[j];
      if (lo && hi) begin
        flag_cnt = flag_cnt | CW'(j);
      end
    end
  end

  // Broadcast control to the row.
  always_comb begin
    ctrl = '0;
    if (state_q == S_IDLE) begin
      ctrl.key    = marker_value_i;
      ctrl.ins_en = accept && (op == OP_INSERT) && (cnt_q != CW'(N));
    end else if (state_q == S_CMP) begin
      ctrl.key    = cur_q;
      ctrl.cmp_en = 1'b1;
    end else if (state_q == S_CMP2) begin
      ctrl.key    = anchor_q;
      ctrl.cmp_en = 1'b1;
      ctrl.cmp_lt = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    logic [SW-1:0]       pos_idx;
    logic [SW-1:0]       neg_idx;
    logic [OFFSET_W-1:0] mag;
    state_d      = state_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    off_d        = off_q;
    above_d      = above_q;
    anchor_d     = anchor_q;
    tgt_d        = tgt_q;
    tgt_ok_d     = tgt_ok_q;
    use_anc_d    = use_anc_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    pos_idx      = SW'(above_q) + SW'(off_q[OFFSET_W-2:0]) - SW'(1);
    mag          = OFFSET_W'(-off_q);
    neg_idx      = SW'(flag_cnt) - SW'(mag);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cur_d        = current_frame_i;
          off_d        = marker_offset_i;
          res_frame_d  = '0;
          res_status_d = 1'b0;
          pend_d       = 1'b1;
          case (op)
            OP_CLEAR: cnt_d = '0;
            OP_INSERT: begin
              if (cnt_q == CW'(N)) begin
                res_status_d = 1'b1;
              end else begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            OP_QUERY: begin
              pend_d  = 1'b0;
              state_d = S_CMP;
            end
            default: ;
          endcase
        end
      end
      S_CMP: state_d = S_ENC;
      S_ENC: begin
        above_d = flag_cnt;
        state_d = S_ANC;
      end
      S_ANC: begin
        anchor_d = rd_or;
        state_d  = S_CMP2;
      end
      S_CMP2: state_d = S_SEL;
      S_SEL: begin
        use_anc_d = 1'b0;
        tgt_ok_d  = 1'b0;
        tgt_d     = pos_idx[IW-1:0];
        if (off_q > 0) begin
          tgt_ok_d = pos_idx < SW'(cnt_q);
        end else if (off_q == 0) begin
          use_anc_d = above_q != '0;
        end else begin
          tgt_d    = neg_idx[IW-1:0];
          tgt_ok_d = (above_q != '0) && (anchor_q != '0) && (SW'(mag) <= SW'(flag_cnt));
        end
        state_d = S_RD;
      end
      S_RD: begin
        res_frame_d  = use_anc_q ? anchor_q : (tgt_ok_q ? rd_or : '0);
        res_status_d = 1'b0;
        pend_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // Drain the pending result into the output slot.
    if (pend_q && slot_free) begin
      pend_d = 1'b0;
    end
  end

  // Output register: hold while stalled, load when the slot frees up.
  always_comb begin
    out_valid_d = out_valid_q;
    frame_d     = frame_q;
    status_d    = status_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && slot_free) begin
      out_valid_d = 1'b1;
      frame_d     = res_frame_q;
      status_d    = res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    off_q        <= off_d;
    above_q      <= above_d;
    anchor_q     <= anchor_d;
    tgt_q        <= tgt_d;
    tgt_ok_q     <= tgt_ok_d;
    use_anc_q    <= use_anc_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    frame_q      <= frame_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign frame_o     = frame_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/smr_cell.sv =====
// One storage cell of the sorted marker row.
// Holds one marker value, hands it to the right neighbor on insert, and
// keeps a compare flag for queries. Depends on smr_pkg.
module smr_cell import smr_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic               occ_i,       // cell index is below the fill count
  input  logic               at_end_i,    // cell index equals the fill count
  input  logic [FRAME_W-1:0] left_val_i,
  input  logic               left_gt_i,
  input  logic               sel_i,
  output logic [FRAME_W-1:0] val_o,
  output logic               gt_o,
  output logic               flag_o,
  output logic [FRAME_W-1:0] rd_o
);

  logic [FRAME_W-1:0] val_q, val_d;
  logic               flag_q, flag_d;
  logic               take;

  assign gt_o = occ_i && (val_q > ctrl_i.key);
  assign take = ctrl_i.ins_en && (gt_o || at_end_i);

  always_comb begin
    val_d = val_q;
    if (take) begin
      val_d = left_gt_i ? left_val_i : ctrl_i.key;
    end
  end

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.cmp_en) begin
      flag_d = occ_i && (ctrl_i.cmp_lt ? (val_q < ctrl_i.key) : (val_q <= ctrl_i.key));
    end
  end

  // Payload only: no reset needed.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    flag_q <= flag_d;
  end

  assign val_o  = val_q;
  assign flag_o = flag_q;
  assign rd_o   = sel_i ? val_q : '0;

endmodule

// ===== verif/tb_sorted_marker_relative_lookup.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_marker_relative_lookup: a directed table, then
// random clear/insert/query episodes, each beat checked against a local marker table.
// Depends on smr_pkg and the block's RTL.
module tb_sorted_marker_relative_lookup;
  import smr_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_MARKERS_DEF;
  localparam int          ITEMS_TOTAL = 1300;
  localparam int          QUIET_TAIL  = 150;   // last beats run with no idling
  localparam int          HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int          HOLD_AT     = 400;   // beat count that triggers the hold-off
  localparam int          WATCHDOG    = 4000;  // cycles with no handshake before giving up
  localparam int          TAIL_CYCLES = 32;
  localparam int          MAX_REPORTS = 10;

  // One row of the directed table. Where typed is set, the row carries its own
  // expected result; otherwise the local table predicts it.
  typedef struct packed {
    op_e                        op;
    logic [FRAME_W-1:0]         value;
    logic [FRAME_W-1:0]         cur;
    logic signed [OFFSET_W-1:0] offset;
    logic                       typed;
    logic [FRAME_W-1:0]         frame;
    logic                       status;
  } marker_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               status;
  } marker_result_t;

  localparam int DIR_ROWS = 24;
  localparam marker_beat_t DIRECTED_ROWS [DIR_ROWS] = '{
    // empty table: every query gives 0
    '{OP_QUERY,  16'd0,      16'd1234,   8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd0,      8'sd127,  1'b1, 16'd0,      1'b0},
    // no operation with every payload bit high
    '{OP_NOP,    16'hFFFF,   16'hFFFF,   -8'sd1,   1'b1, 16'd0,      1'b0},
    '{OP_INSERT, 16'd0,      16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    // anchor of value zero: offset 0 returns it, negative offsets give 0
    '{OP_QUERY,  16'd0,      16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd0,      -8'sd1,   1'b1, 16'd0,      1'b0},
    '{OP_INSERT, 16'hFFFF,   16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    // duplicates count as separate markers
    '{OP_INSERT, 16'd100,    16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_INSERT, 16'd100,    16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_INSERT, 16'd7,      16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd100,    8'sd1,    1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'hFFFF,   8'sd0,    1'b1, 16'hFFFF,   1'b0},
    // offsets that reach past the table
    '{OP_QUERY,  16'd0,      16'hFFFF,   8'sh80,   1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd0,      8'sd127,  1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd100,    -8'sd1,   1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd100,    -8'sd2,   1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd99,     8'sd0,    1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd6,      -8'sd1,   1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'd0,      8'sd1,    1'b0, 16'd0,      1'b0},
    '{OP_CLEAR,  16'hFFFF,   16'hFFFF,   -8'sd1,   1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'hFFFF,   8'sd0,    1'b1, 16'd0,      1'b0},
    // no anchor at all: marker only above the frame
    '{OP_INSERT, 16'h8000,   16'd0,      8'sd0,    1'b1, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'h7FFF,   8'sd1,    1'b0, 16'd0,      1'b0},
    '{OP_QUERY,  16'd0,      16'h7FFF,   -8'sd1,   1'b0, 16'd0,      1'b0}
  };

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 op_i            = OP_NOP;
  logic [FRAME_W-1:0]         marker_value_i  = '0;
  logic [FRAME_W-1:0]         current_frame_i = '0;
  logic signed [OFFSET_W-1:0] marker_offset_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic [FRAME_W-1:0]         frame_o;
  logic                       status_o;

  sorted_marker_relative_lookup DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .marker_value_i  (marker_value_i),
    .current_frame_i (current_frame_i),
    .marker_offset_i (marker_offset_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_o         (frame_o),
    .status_o        (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Local copy of the marker table, kept ascending.
  logic [FRAME_W-1:0] marker_tbl [TABLE_DEPTH];
  int unsigned        marker_fill = 0;

  marker_result_t pending_results [$];
  int             mismatches    = 0;
  int             beats_counted = 0;

  // Idling knobs, changed per episode by the stimulus process.
  int idle_pct    = 0;
  int rx_pct      = 0;
  bit hold_start  = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int rx_burst    = 0;

  function automatic int unsigned count_at_or_under(logic [FRAME_W-1:0] v);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < marker_fill; i++)
      if (marker_tbl[i] <= v) n++;
    return n;
  endfunction

  function automatic int unsigned count_under(logic [FRAME_W-1:0] v);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < marker_fill; i++)
      if (marker_tbl[i] < v) n++;
    return n;
  endfunction

  // Resolve a relative lookup against the local table.
  function automatic logic [FRAME_W-1:0] resolve_marker(logic [FRAME_W-1:0] cur,
                                                        logic signed [OFFSET_W-1:0] off);
    int                 o;
    int unsigned        after_cnt;
    int unsigned        under_cnt;
    int unsigned        k;
    logic [FRAME_W-1:0] anchor;
    o = off;
    if (marker_fill == 0) return '0;
    after_cnt = count_at_or_under(cur);
    if (o > 0) begin
      k = o;
      if (after_cnt + k - 1 < marker_fill) return marker_tbl[after_cnt + k - 1];
      return '0;
    end
    if (after_cnt == 0) return '0;
    anchor = marker_tbl[after_cnt - 1];
    if (o == 0) return anchor;
    if (anchor == 0) return '0;
    k = -o;
    under_cnt = count_under(anchor);
    if (k <= under_cnt) return marker_tbl[under_cnt - k];
    return '0;
  endfunction

  // Apply one beat to the local table and return the result it should give.
  function automatic marker_result_t predict_marker_beat(op_e op, logic [FRAME_W-1:0] val,
                                                         logic [FRAME_W-1:0] cur,
                                                         logic signed [OFFSET_W-1:0] off);
    marker_result_t r;
    int unsigned    pos;
    r = '0;
    case (op)
      OP_CLEAR: begin
        marker_fill = 0;
      end
      OP_INSERT: begin
        if (marker_fill >= TABLE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          // new value goes after any equal ones
          pos = count_at_or_under(val);
          for (int unsigned i = marker_fill; i > pos; i--) marker_tbl[i] = marker_tbl[i - 1];
          marker_tbl[pos] = val;
          marker_fill++;
        end
      end
      OP_QUERY: begin
        r.frame = resolve_marker(cur, off);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, hold it until accepted, record its expected result, then
  // optionally drop valid for a random gap. Called and returns at a rising edge.
  task automatic send_beat(input op_e op, input logic [FRAME_W-1:0] val,
                           input logic [FRAME_W-1:0] cur,
                           input logic signed [OFFSET_W-1:0] off,
                           input logic typed, input logic [FRAME_W-1:0] t_frame,
                           input logic t_status);
    marker_result_t expd;
    int             gap;
    op_i            <= op;
    marker_value_i  <= val;
    current_frame_i <= cur;
    marker_offset_i <= off;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expd = predict_marker_beat(op, val, cur, off);
    if (typed) begin
      expd.frame  = t_frame;
      expd.status = t_status;
    end
    pending_results = {pending_results, expd};
    if (op != OP_NOP) beats_counted++;
    // closing stretch: no more idling on either side
    if (beats_counted >= ITEMS_TOTAL - QUIET_TAIL) begin
      idle_pct = 0;
      rx_pct   = 0;
    end
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(16, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Query aimed at an existing marker about half the time, offsets mostly within the fill count either way.
  task automatic random_query();
    logic [FRAME_W-1:0]         cur;
    logic signed [OFFSET_W-1:0] off;
    int                         pick;
    int                         span;
    int                         o;
    pick = $urandom_range(9);
    if (pick <= 4 && marker_fill > 0)
      cur = marker_tbl[$urandom_range(marker_fill - 1)] + FRAME_W'($urandom_range(2)) - 16'd1;
    else if (pick == 7)
      cur = '0;
    else if (pick == 8)
      cur = '1;
    else if (pick == 9)
      cur = FRAME_W'($urandom_range(31));
    else
      cur = FRAME_W'($urandom_range(65535));
    if ($urandom_range(9) < 8) begin
      span = marker_fill + 2;
      o = $urandom_range(2 * span) - span;
      if (o > 127) o = 127;
      if (o < -128) o = -128;
      off = o[OFFSET_W-1:0];
    end else begin
      off = OFFSET_W'($urandom_range(255));
    end
    send_beat(OP_QUERY, FRAME_W'($urandom_range(65535)), cur, off, 1'b0, '0, 1'b0);
  endtask

  // Occasional noise: a no-op or a stray clear with random payload.
  task automatic noise_beat();
    op_e op;
    op = ($urandom_range(3) == 0) ? OP_CLEAR : OP_NOP;
    send_beat(op, FRAME_W'($urandom_range(65535)), FRAME_W'($urandom_range(65535)),
              OFFSET_W'($urandom_range(255)), 1'b0, '0, 1'b0);
  endtask

  // Stimulus: reset, the directed table, then random episodes.
  initial begin
    int                 mode;
    int                 n_ins;
    int                 n_q;
    logic [FRAME_W-1:0] base;
    logic [FRAME_W-1:0] val;
    int                 pcts [4];
    pcts = '{0, 10, 30, 60};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].cur,
                DIRECTED_ROWS[i].offset, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].frame,
                DIRECTED_ROWS[i].status);

    while (beats_counted < ITEMS_TOTAL) begin
      // pick idling for this episode; none in the closing stretch
      if (beats_counted >= ITEMS_TOTAL - QUIET_TAIL) begin
        idle_pct = 0;
        rx_pct   = 0;
      end else begin
        idle_pct = pcts[$urandom_range(3)];
        rx_pct   = pcts[$urandom_range(3)];
      end
      // hold off the receiver once so the block backs up into its input
      if (beats_counted >= HOLD_AT && !hold_start) hold_start = 1'b1;

      // most episodes start from an empty table; the rest build on what is there
      if ($urandom_range(9) < 8)
        send_beat(OP_CLEAR, FRAME_W'($urandom_range(65535)), FRAME_W'($urandom_range(65535)),
                  OFFSET_W'($urandom_range(255)), 1'b0, '0, 1'b0);
      mode  = $urandom_range(2);
      base  = FRAME_W'($urandom_range(65535));
      n_ins = ($urandom_range(99) < 15) ? $urandom_range(72, 60) : $urandom_range(24, 1);
      for (int i = 0; i < n_ins; i++) begin
        case (mode)
          0: val = FRAME_W'($urandom_range(15));
          1: val = FRAME_W'($urandom_range(65535));
          default: begin
            case ($urandom_range(3))
              0: val = '0;
              1: val = '1;
              default: val = base + FRAME_W'($urandom_range(8));
            endcase
          end
        endcase
        if ($urandom_range(19) == 0) noise_beat();
        send_beat(OP_INSERT, val, FRAME_W'($urandom_range(65535)),
                  OFFSET_W'($urandom_range(255)), 1'b0, '0, 1'b0);
        if ($urandom_range(9) < 3) random_query();
      end
      n_q = $urandom_range(16, 4);
      for (int i = 0; i < n_q; i++) begin
        if ($urandom_range(19) == 0) noise_beat();
        random_query();
      end
    end
    in_valid_i <= 1'b0;

    // drain, then give the block time to show any stray beat
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Compare one output beat with the oldest expectation.
  task automatic check_result();
    marker_result_t expd;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result beat: frame %h status %b", frame_o, status_o);
    end else begin
      expd = pending_results.pop_front();
      if (frame_o !== expd.frame || status_o !== expd.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: frame exp %h got %h, status exp %b got %b",
                   expd.frame, frame_o, expd.status, status_o);
      end
    end
  endtask

  // Receiver: check accepted beats and drive stall in random bursts, plus one
  // long hold-off counted here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_start && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall_i <= 1'b1;
      end else if (rx_pct != 0 && $urandom_range(399) < rx_pct) begin
        rx_burst = $urandom_range(15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: give up after too many cycles without any handshake.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sorted_marker_relative_lookup.f =====
rtl/smr_pkg.sv
rtl/smr_cell.sv
rtl/sorted_marker_relative_lookup.sv
verif/tb_sorted_marker_relative_lookup.sv
